/* src/khs_pkg.sv */
// ----------------------------------------------------------------------------
// khs_pkg
// Types, constants and the CRC16 byte step shared by the key hash slot block.
// ----------------------------------------------------------------------------
`default_nettype none

package khs_pkg;

  localparam int          SLOT_W      = 14;
  localparam int          CRC_W       = 16;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [7:0]  OPEN_BRACE  = 8'h7B;
  localparam logic [7:0]  CLOSE_BRACE = 8'h7D;

  // Where the hash tag search stands within the current key
  typedef enum logic [1:0] {
    PH_NONE,
    PH_INSIDE,
    PH_CLOSED
  } tag_phase_t;

  // One classified key beat, as queued between front and back
  typedef struct packed {
    logic [7:0] key_byte;
    logic       last_byte;
    logic       no_byte;
    logic       is_open;
    logic       is_close;
  } khs_item_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } khs_q_stat_t;

  // CRC16-XMODEM over one byte, MSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/khs_if.sv */
// ----------------------------------------------------------------------------
// khs_if
// Valid/ready channels: key beats in, hash slot results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface khs_key_if;
  logic       valid;
  logic       ready;
  logic [7:0] key_byte;
  logic       last_byte;
  logic       no_byte;

  modport source (output valid, output key_byte, output last_byte, output no_byte,
                  input ready);
  modport sink   (input valid, input key_byte, input last_byte, input no_byte,
                  output ready);
endinterface

interface khs_slot_if;
  logic        valid;
  logic        ready;
  logic [13:0] slot;
  logic        tag_used;

  modport source (output valid, output slot, output tag_used, input ready);
  modport sink   (input valid, input slot, input tag_used, output ready);
endinterface

`default_nettype wire

/* src/khs_front.sv */
// ----------------------------------------------------------------------------
// khs_front
// Accepts key beats and tags brace bytes before they enter the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module khs_front
  import khs_pkg::*;
(
  khs_key_if.sink     keys,
  input  khs_q_stat_t q_stat,
  output logic        push,
  output khs_item_t   item
);

  // Take a beat whenever the queue has room
  assign keys.ready = !q_stat.full;
  assign push       = keys.valid && !q_stat.full;

  // Classify the byte; a byte-less beat never counts as a brace
  always_comb begin
    item.key_byte  = keys.key_byte;
    item.last_byte = keys.last_byte;
    item.no_byte   = keys.no_byte;
    item.is_open   = !keys.no_byte && (keys.key_byte == OPEN_BRACE);
    item.is_close  = !keys.no_byte && (keys.key_byte == CLOSE_BRACE);
  end

endmodule

`default_nettype wire

/* src/khs_fifo.sv */
// ----------------------------------------------------------------------------
// khs_fifo
// Short queue of classified beats between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module khs_fifo
  import khs_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  khs_item_t   wr_item,
  input  logic        pop,
  output khs_item_t   rd_item,
  output khs_q_stat_t stat
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  khs_item_t        entries [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage, payload only
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  assign rd_item    = entries[rd_ptr];
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    stat.full |-> !push)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    stat.empty |-> !pop)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

/* src/khs_back.sv */
// ----------------------------------------------------------------------------
// khs_back
// Runs the whole-key and tag CRCs and registers one slot result per key.
// ----------------------------------------------------------------------------
`default_nettype none

module khs_back
  import khs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  khs_item_t   item,
  input  khs_q_stat_t q_stat,
  output logic        pop,
  khs_slot_if.source  slots
);

  logic [CRC_W-1:0]  whole_crc, whole_crc_next;
  logic [CRC_W-1:0]  tag_crc, tag_crc_next;
  tag_phase_t        phase, phase_next;
  logic              tag_nonempty, tag_nonempty_next;
  logic              res_valid;
  logic [SLOT_W-1:0] res_slot;
  logic              res_tag_used;
  logic [CRC_W-1:0]  upd_whole, upd_tag;
  tag_phase_t        upd_phase;
  logic              upd_nonempty;
  logic              used;

  // Next beat goes when the result register is free or being drained
  assign pop = !q_stat.empty && (!res_valid || slots.ready);

  // CRC and tag tracking for the head beat
  always_comb begin
    upd_whole    = whole_crc;
    upd_tag      = tag_crc;
    upd_phase    = phase;
    upd_nonempty = tag_nonempty;
    if (!item.no_byte) begin
      upd_whole = crc16_step(whole_crc, item.key_byte);
      case (phase)
        PH_NONE: begin
          if (item.is_open) begin
            upd_phase = PH_INSIDE;
          end
        end
        PH_INSIDE: begin
          if (item.is_close) begin
            upd_phase = PH_CLOSED;
          end else begin
            upd_tag      = crc16_step(tag_crc, item.key_byte);
            upd_nonempty = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    used = (upd_phase == PH_CLOSED) && upd_nonempty;

    whole_crc_next    = whole_crc;
    tag_crc_next      = tag_crc;
    phase_next        = phase;
    tag_nonempty_next = tag_nonempty;
    if (pop) begin
      if (item.last_byte) begin
        whole_crc_next    = '0;
        tag_crc_next      = '0;
        phase_next        = PH_NONE;
        tag_nonempty_next = 1'b0;
      end else begin
        whole_crc_next    = upd_whole;
        tag_crc_next      = upd_tag;
        phase_next        = upd_phase;
        tag_nonempty_next = upd_nonempty;
      end
    end
  end

  // Key state
  always_ff @(posedge clk) begin
    if (rst) begin
      whole_crc    <= '0;
      tag_crc      <= '0;
      phase        <= PH_NONE;
      tag_nonempty <= 1'b0;
    end else begin
      whole_crc    <= whole_crc_next;
      tag_crc      <= tag_crc_next;
      phase        <= phase_next;
      tag_nonempty <= tag_nonempty_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop && item.last_byte) begin
      res_valid <= 1'b1;
    end else if (slots.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && item.last_byte) begin
      res_slot     <= used ? upd_tag[SLOT_W-1:0] : upd_whole[SLOT_W-1:0];
      res_tag_used <= used;
    end
  end

  assign slots.valid    = res_valid;
  assign slots.slot     = res_slot;
  assign slots.tag_used = res_tag_used;

  a_clear_after_key: assert property (@(posedge clk) disable iff (rst)
    pop && item.last_byte |=> whole_crc == '0 && phase == PH_NONE && !tag_nonempty)
    else $error("key state not cleared after last beat");

  a_tag_idle_clean: assert property (@(posedge clk) disable iff (rst)
    phase == PH_NONE |-> tag_crc == '0 && !tag_nonempty)
    else $error("tag state set before opening brace");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !slots.ready |-> !pop)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

/* src/key_hash_slot_with_tag_top.sv */
// ----------------------------------------------------------------------------
// key_hash_slot_with_tag_top
// Key hash slot: CRC16-XMODEM of the key, or of its braced tag, to 14 bits.
// ----------------------------------------------------------------------------
//  channel | dir | payload                              | beat
//  keys    | in  | key_byte[7:0], last_byte, no_byte    | one key byte
//  slots   | out | slot[13:0], tag_used                 | one result per key
//
//  One beat per cycle while no result stalls the back; the CRC byte step in the back stage sets it.
//  A result is registered in the back when its last beat is popped from the queue.
//  rst (synchronous) empties the queue, clears the key state and the result.
//  A stalled result holds the back; FIFO_DEPTH queued beats keep keys moving.
// ----------------------------------------------------------------------------
`default_nettype none

module key_hash_slot_with_tag_top
  import khs_pkg::*;
#(
  parameter int FIFO_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  khs_key_if.sink    keys,
  khs_slot_if.source slots
);

  khs_item_t   in_item;
  khs_item_t   head_item;
  khs_q_stat_t q_stat;
  logic        push;
  logic        pop;

  khs_front u_front (
    .keys   (keys),
    .q_stat (q_stat),
    .push   (push),
    .item   (in_item)
  );

  khs_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (in_item),
    .pop     (pop),
    .rd_item (head_item),
    .stat    (q_stat)
  );

  khs_back u_back (
    .clk    (clk),
    .rst    (rst),
    .item   (head_item),
    .q_stat (q_stat),
    .pop    (pop),
    .slots  (slots)
  );

endmodule

`default_nettype wire
